FILE: hw/rtl/pirm_pkg.sv
// ----------------------------------------------------------------------------
// pirm_pkg
// Shared types, constants and the control store of the positional-insert,
// range-minimum block.
// ----------------------------------------------------------------------------
`default_nettype none

package pirm_pkg;

  // Fixed field widths
  localparam int POS_W  = 11;
  localparam int DATA_W = 32;

  // Step numbers of the control program
  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_I_CHECK  = 3'd2;
  localparam step_t STEP_I_SHIFT  = 3'd3;
  localparam step_t STEP_I_PUT    = 3'd4;
  localparam step_t STEP_Q_CHECK  = 3'd5;
  localparam step_t STEP_Q_SCAN   = 3'd6;
  localparam step_t STEP_DONE     = 3'd7;

  // Datapath operation of one step
  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_NONE    = 3'd1,
    ACT_I_SETUP = 3'd2,
    ACT_SHIFT   = 3'd3,
    ACT_PUT     = 3'd4,
    ACT_Q_SETUP = 3'd5,
    ACT_SCAN    = 3'd6,
    ACT_DELIVER = 3'd7
  } act_t;

  // Jump condition of one step
  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_FIRE      = 3'd1,
    COND_QUERY     = 3'd2,
    COND_FULL      = 3'd3,
    COND_BAD       = 3'd4,
    COND_SHIFT_END = 3'd5,
    COND_SCAN_END  = 3'd6,
    COND_OUT_FREE  = 3'd7
  } cond_t;

  // One control word: jump to target when cond holds, otherwise
  // stay (hold set) or step on to the next word
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    logic  hold;
  } ctrl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic fire;
    logic is_query;
    logic full;
    logic bad;
    logic shift_end;
    logic scan_end;
    logic out_free;
  } dp_status_t;

  // Control store
  function automatic ctrl_word_t seq_rom(input step_t step);
    ctrl_word_t cw;
    begin
      cw = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE, hold: 1'b0};
      case (step)
        STEP_IDLE:     cw = '{act: ACT_LOAD,    cond: COND_FIRE,
                              target: STEP_DISPATCH, hold: 1'b1};
        STEP_DISPATCH: cw = '{act: ACT_NONE,    cond: COND_QUERY,
                              target: STEP_Q_CHECK, hold: 1'b0};
        STEP_I_CHECK:  cw = '{act: ACT_I_SETUP, cond: COND_FULL,
                              target: STEP_DONE, hold: 1'b0};
        STEP_I_SHIFT:  cw = '{act: ACT_SHIFT,   cond: COND_SHIFT_END,
                              target: STEP_I_PUT, hold: 1'b1};
        STEP_I_PUT:    cw = '{act: ACT_PUT,     cond: COND_ALWAYS,
                              target: STEP_DONE, hold: 1'b0};
        STEP_Q_CHECK:  cw = '{act: ACT_Q_SETUP, cond: COND_BAD,
                              target: STEP_DONE, hold: 1'b0};
        STEP_Q_SCAN:   cw = '{act: ACT_SCAN,    cond: COND_SCAN_END,
                              target: STEP_DONE, hold: 1'b1};
        STEP_DONE:     cw = '{act: ACT_DELIVER, cond: COND_OUT_FREE,
                              target: STEP_IDLE, hold: 1'b1};
        default:       cw = '{act: ACT_NONE,    cond: COND_ALWAYS,
                              target: STEP_IDLE, hold: 1'b0};
      endcase
      return cw;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pirm_ram.sv
// ----------------------------------------------------------------------------
// pirm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pirm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pirm_seq.sv
// ----------------------------------------------------------------------------
// pirm_seq
// Step counter and control store: issues one control word per cycle and
// takes conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pirm_seq
  import pirm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_status_t status,
  output ctrl_word_t      cw
);

  step_t pc_r;
  step_t pc_nxt;
  logic  cond_ok;

  // Fetch the current control word
  assign cw = seq_rom(pc_r);

  // Select the jump condition
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_FIRE:      cond_ok = status.fire;
      COND_QUERY:     cond_ok = status.is_query;
      COND_FULL:      cond_ok = status.full;
      COND_BAD:       cond_ok = status.bad;
      COND_SHIFT_END: cond_ok = status.shift_end;
      COND_SCAN_END:  cond_ok = status.scan_end;
      COND_OUT_FREE:  cond_ok = status.out_free;
      default:        cond_ok = 1'b1;
    endcase
  end

  // Jump, hold or advance
  always_comb begin
    if (cond_ok) begin
      pc_nxt = cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/positional_insert_range_min.sv
// ----------------------------------------------------------------------------
// positional_insert_range_min
// Ordered sequence of signed 32-bit values with positional insert and
// range-minimum query, run by a microcoded sequencer over one RAM.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in_      request    in_valid/in_ready    req_type, insert_after, value,
//                                            first_pos, last_pos
//   out_     result     out_valid/out_ready  min_value, error
//
// One request at a time. The shift loop of an insert moves one entry per
// cycle through the RAM's single write port, and a query reads one entry
// per cycle. Reset clears the length, the pending flag, the output valid
// and the step counter; the store needs no clearing. The result sits in an
// output register, and the next request is taken while it waits; a stalled
// result holds the sequencer at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_range_min
  import pirm_pkg::*;
#(
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_req_type,
  input  wire logic        [POS_W-1:0]  in_insert_after,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic        [POS_W-1:0]  in_first_pos,
  input  wire logic        [POS_W-1:0]  in_last_pos,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed      [DATA_W-1:0] out_min_value,
  output logic                          out_error
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int LW = $clog2(MAX_ITEMS + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  ctrl_word_t cw;
  dp_status_t status;

  // Request registers
  logic              kind_r,  kind_nxt;
  logic [POS_W-1:0]  after_r, after_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [POS_W-1:0]  lo_r,    lo_nxt;
  logic [POS_W-1:0]  hi_r,    hi_nxt;

  // Working registers
  logic [LW-1:0]     length_r,   length_nxt;
  logic [LW-1:0]     idx_r,      idx_nxt;
  logic [LW-1:0]     at_r,       at_nxt;
  logic [LW-1:0]     lim_r,      lim_nxt;
  logic              pend_r,     pend_nxt;
  logic [AW-1:0]     pend_adr_r, pend_adr_nxt;
  logic              first_r,    first_nxt;
  logic [DATA_W-1:0] best_r,     best_nxt;
  logic              err_r,      err_nxt;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_min_r,   out_min_nxt;
  logic              out_err_r,   out_err_nxt;

  // RAM port
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              fire;
  logic              out_free;
  logic [CW-1:0]     after_ext, lo_ext, hi_ext, len_ext;
  logic [LW-1:0]     idx_dec, idx_inc;
  logic [POS_W-1:0]  lo_dec;
  logic              full, bad;

  pirm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cw     (cw)
  );

  pirm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake
  assign in_ready = (cw.act == ACT_LOAD);
  assign fire     = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // Checks on the captured request
  assign after_ext = CW'(after_r);
  assign lo_ext    = CW'(lo_r);
  assign hi_ext    = CW'(hi_r);
  assign len_ext   = CW'(length_r);
  assign full      = (length_r == LW'(MAX_ITEMS));
  assign bad       = (lo_r == '0) || (lo_ext > hi_ext) || (hi_ext > len_ext);
  assign idx_dec   = idx_r - LW'(1);
  assign idx_inc   = idx_r + LW'(1);
  assign lo_dec    = lo_r - POS_W'(1);

  // Flags for the sequencer
  always_comb begin
    status.fire      = fire;
    status.is_query  = kind_r;
    status.full      = full;
    status.bad       = bad;
    status.shift_end = (idx_r == at_r);
    status.scan_end  = (idx_r == lim_r);
    status.out_free  = out_free;
  end

  // Store write port: pending shifted entry, or the new value
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_adr_r;
    wr_data = rd_data;
    if (cw.act == ACT_SHIFT && pend_r) begin
      wr_en = 1'b1;
    end else if (cw.act == ACT_PUT) begin
      wr_en   = 1'b1;
      wr_addr = at_r[AW-1:0];
      wr_data = value_r;
    end
  end

  // Store read port: walk down for the shift, up for the scan
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    if (cw.act == ACT_SHIFT && idx_r != at_r) begin
      rd_en   = 1'b1;
      rd_addr = idx_dec[AW-1:0];
    end else if (cw.act == ACT_SCAN && idx_r != lim_r) begin
      rd_en = 1'b1;
    end
  end

  // Datapath operations
  always_comb begin
    kind_nxt      = kind_r;
    after_nxt     = after_r;
    value_nxt     = value_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    length_nxt    = length_r;
    idx_nxt       = idx_r;
    at_nxt        = at_r;
    lim_nxt       = lim_r;
    pend_nxt      = pend_r;
    pend_adr_nxt  = pend_adr_r;
    first_nxt     = first_r;
    best_nxt      = best_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_min_nxt   = out_min_r;
    out_err_nxt   = out_err_r;

    case (cw.act)
      // Capture the request
      ACT_LOAD: begin
        if (fire) begin
          kind_nxt  = in_req_type;
          after_nxt = in_insert_after;
          value_nxt = in_value;
          lo_nxt    = in_first_pos;
          hi_nxt    = in_last_pos;
        end
      end
      // Clamp the position and start the shift at the top
      ACT_I_SETUP: begin
        err_nxt  = full;
        best_nxt = '0;
        pend_nxt = 1'b0;
        idx_nxt  = length_r;
        at_nxt   = (after_ext > len_ext) ? length_r : LW'(after_r);
      end
      // Move one entry up per cycle
      ACT_SHIFT: begin
        if (idx_r != at_r) begin
          pend_nxt     = 1'b1;
          pend_adr_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_dec;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      // Drop the new value into the gap
      ACT_PUT: begin
        length_nxt = length_r + LW'(1);
      end
      // Set up the scan range
      ACT_Q_SETUP: begin
        err_nxt   = bad;
        best_nxt  = '0;
        first_nxt = 1'b1;
        pend_nxt  = 1'b0;
        idx_nxt   = LW'(lo_dec);
        lim_nxt   = LW'(hi_r);
      end
      // Read one entry per cycle and keep the running minimum
      ACT_SCAN: begin
        pend_nxt = (idx_r != lim_r);
        if (idx_r != lim_r) begin
          idx_nxt = idx_inc;
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r || ($signed(rd_data) < $signed(best_r))) begin
            best_nxt = rd_data;
          end
        end
      end
      // Hand the result to the output register
      ACT_DELIVER: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = best_r;
          out_err_nxt   = err_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      length_r    <= length_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    after_r    <= after_nxt;
    value_r    <= value_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    at_r       <= at_nxt;
    lim_r      <= lim_nxt;
    pend_adr_r <= pend_adr_nxt;
    first_r    <= first_nxt;
    best_r     <= best_nxt;
    err_r      <= err_nxt;
    out_min_r  <= out_min_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_error     = out_err_r;

endmodule

`default_nettype wire

FILE: sim/positional_insert_range_min_tb.sv
// ----------------------------------------------------------------------------
// positional_insert_range_min_tb
// Drives insert and range-minimum requests into the sequence store and checks
// each result against a behavioural copy of the sequence or a pinned result.
// A short directed table comes first, then random traffic, then a closing
// stretch without idling that includes a whole-length scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_range_min_tb
  import pirm_pkg::*;
;

  localparam int MAX_ITEMS   = 1024;
  localparam int MIXED_COUNT = 500;
  localparam int TAIL_COUNT  = 60;
  localparam int DRAIN_WAIT  = 1100;
  localparam int CYCLE_LIMIT = 6000000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t                  kind;
    logic        [POS_W-1:0]    insert_after;
    logic signed [DATA_W-1:0]   value;
    logic        [POS_W-1:0]    first_pos;
    logic        [POS_W-1:0]    last_pos;
  } request_t;

  typedef struct {
    logic signed [DATA_W-1:0]   min_value;
    logic                       error;
  } outcome_t;

  typedef struct {
    request_t rq;
    bit       pinned;
    outcome_t res;
  } table_row_t;

  logic                     clk;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic                     in_req_type     = 1'b0;
  logic        [POS_W-1:0]  in_insert_after = '0;
  logic signed [DATA_W-1:0] in_value        = '0;
  logic        [POS_W-1:0]  in_first_pos    = '0;
  logic        [POS_W-1:0]  in_last_pos     = '0;
  logic                     out_valid;
  logic                     out_ready       = 1'b1;
  logic signed [DATA_W-1:0] out_min_value;
  logic                     out_error;

  // Bench copy of the sequence
  logic signed [DATA_W-1:0] seq_copy [0:MAX_ITEMS-1];
  int                       seq_len;

  outcome_t   pending_outcomes [$];
  table_row_t directed_rows [$];
  int         fail_count;
  int         cycle_count;
  bit         calm;
  bit         in_quiet;
  bit         out_quiet;

  positional_insert_range_min #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_insert_after (in_insert_after),
    .in_value        (in_value),
    .in_first_pos    (in_first_pos),
    .in_last_pos     (in_last_pos),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_value   (out_min_value),
    .out_error       (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the bench copy and work out its result
  function automatic outcome_t apply_request(input request_t rq);
    outcome_t                 res;
    int                       at;
    int                       i;
    logic signed [DATA_W-1:0] best;
    res.min_value = '0;
    res.error     = 1'b0;
    if (rq.kind == REQ_INSERT) begin
      if (seq_len >= MAX_ITEMS) begin
        res.error = 1'b1;
      end else begin
        at = (int'(rq.insert_after) > seq_len) ? seq_len : int'(rq.insert_after);
        for (i = seq_len; i > at; i--) seq_copy[i] = seq_copy[i-1];
        seq_copy[at] = rq.value;
        seq_len++;
      end
    end else begin
      if (rq.first_pos == 0 || rq.first_pos > rq.last_pos ||
          int'(rq.last_pos) > seq_len) begin
        res.error = 1'b1;
      end else begin
        best = seq_copy[rq.first_pos-1];
        for (i = int'(rq.first_pos); i < int'(rq.last_pos); i++) begin
          if (seq_copy[i] < best) best = seq_copy[i];
        end
        res.min_value = best;
      end
    end
    return res;
  endfunction

  // Random value biased towards the extremes and small numbers to force ties
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return VAL_MIN;
    if (sel == 1) return VAL_MAX;
    if (sel == 2) return $signed(DATA_W'($urandom_range(0, 15))) - 8;
    return $urandom;
  endfunction

  function automatic request_t make_insert(input int after,
                                           input logic signed [DATA_W-1:0] val);
    request_t rq;
    rq.kind         = REQ_INSERT;
    rq.insert_after = POS_W'(after);
    rq.value        = val;
    rq.first_pos    = POS_W'($urandom_range(0, 1024));
    rq.last_pos     = POS_W'($urandom_range(0, 1024));
    return rq;
  endfunction

  function automatic request_t make_query(input int first, input int last);
    request_t rq;
    rq.kind         = REQ_QUERY;
    rq.insert_after = POS_W'($urandom_range(0, 1024));
    rq.value        = $urandom;
    rq.first_pos    = POS_W'(first);
    rq.last_pos     = POS_W'(last);
    return rq;
  endfunction

  // Query with a bad range: zero start, reversed, or past the end
  function automatic request_t make_bad_query();
    int unsigned sel;
    int          last;
    sel = $urandom_range(0, 2);
    if (sel == 2 && seq_len < MAX_ITEMS) begin
      last = $urandom_range(seq_len + 1, MAX_ITEMS);
      return make_query($urandom_range(1, last), last);
    end
    if (sel == 1) begin
      last = $urandom_range(1, MAX_ITEMS - 1);
      return make_query($urandom_range(last + 1, MAX_ITEMS), last);
    end
    return make_query(0, $urandom_range(1, MAX_ITEMS));
  endfunction

  // Query with a good range, often short
  function automatic request_t make_good_query();
    int first;
    int top;
    first = $urandom_range(1, seq_len);
    top   = ($urandom_range(0, 1) == 0 && first + 7 < seq_len) ? first + 7 : seq_len;
    return make_query(first, $urandom_range(first, top));
  endfunction

  // Present one request, hold it until taken, then record its outcome
  task automatic issue(input request_t rq, input bit pinned, input outcome_t pin_res);
    outcome_t res;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    if (!calm && !in_quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= rq.kind;
    in_insert_after <= rq.insert_after;
    in_value        <= rq.value;
    in_first_pos    <= rq.first_pos;
    in_last_pos     <= rq.last_pos;
    do @(posedge clk); while (!in_ready);
    res = apply_request(rq);
    pending_outcomes.push_back(pinned ? pin_res : res);
  endtask

  task automatic add_row(input req_kind_t kind, input int after,
                         input logic signed [DATA_W-1:0] val, input int first,
                         input int last, input bit pinned,
                         input logic signed [DATA_W-1:0] min_value, input logic error);
    table_row_t row;
    row.rq.kind         = kind;
    row.rq.insert_after = POS_W'(after);
    row.rq.value        = val;
    row.rq.first_pos    = POS_W'(first);
    row.rq.last_pos     = POS_W'(last);
    row.pinned          = pinned;
    row.res.min_value   = min_value;
    row.res.error       = error;
    directed_rows.push_back(row);
  endtask

  // Stall the result side in random bursts, with quiet stretches between
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
      if (!calm && !out_quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each delivered result with the oldest outstanding one
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result min_value=%0d error=%0b",
                 $time, out_min_value, out_error);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_min_value !== want.min_value) begin
          $display("%0t: min_value expected %0d actual %0d",
                   $time, want.min_value, out_min_value);
          fail_count++;
        end
        if (out_error !== want.error) begin
          $display("%0t: error expected %0b actual %0b",
                   $time, want.error, out_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    request_t    rq;
    outcome_t    no_pin;
    int unsigned sel;
    int          n;
    seq_len          = 0;
    fail_count       = 0;
    calm             = 1'b0;
    in_quiet         = 1'b0;
    out_quiet        = 1'b0;
    no_pin.min_value = '0;
    no_pin.error     = 1'b0;

    // Empty store, inserts at front, middle and past the end, then queries
    add_row(REQ_QUERY,  0,    '0,      1,    1,    1, '0,      1'b1);
    add_row(REQ_INSERT, 0,    VAL_MIN, 0,    0,    1, '0,      1'b0);
    add_row(REQ_INSERT, 1024, VAL_MAX, 0,    0,    1, '0,      1'b0);
    add_row(REQ_INSERT, 0,    -1,      1024, 1024, 0, '0,      1'b0);
    add_row(REQ_INSERT, 1,    '0,      0,    0,    0, '0,      1'b0);
    add_row(REQ_INSERT, 5,    1,       0,    0,    0, '0,      1'b0);
    add_row(REQ_QUERY,  1024, VAL_MAX, 1,    5,    1, VAL_MIN, 1'b0);
    add_row(REQ_QUERY,  0,    '0,      1,    1,    0, '0,      1'b0);
    add_row(REQ_QUERY,  0,    '0,      4,    4,    1, VAL_MAX, 1'b0);
    add_row(REQ_QUERY,  0,    '0,      4,    5,    0, '0,      1'b0);
    add_row(REQ_QUERY,  0,    '0,      0,    3,    1, '0,      1'b1);
    add_row(REQ_QUERY,  0,    '0,      3,    2,    1, '0,      1'b1);
    add_row(REQ_QUERY,  0,    '0,      1,    6,    1, '0,      1'b1);
    add_row(REQ_QUERY,  0,    '0,      1024, 1024, 1, '0,      1'b1);
    add_row(REQ_QUERY,  0,    '0,      5,    5,    0, '0,      1'b0);
    add_row(REQ_INSERT, 3,    VAL_MAX, 0,    0,    0, '0,      1'b0);
    add_row(REQ_QUERY,  0,    '0,      1,    2,    0, '0,      1'b0);
    add_row(REQ_INSERT, 0,    VAL_MIN, 0,    0,    0, '0,      1'b0);
    add_row(REQ_QUERY,  0,    '0,      1,    7,    1, VAL_MIN, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].rq, directed_rows[i].pinned, directed_rows[i].res);
    end

    // Mixed traffic: inserts anywhere, mostly good queries, some bad ones
    for (n = 0; n < MIXED_COUNT; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)      rq = make_insert(0, pick_value());
        else if (sel == 1) rq = make_insert($urandom_range(seq_len, 1024), pick_value());
        else               rq = make_insert($urandom_range(0, seq_len), pick_value());
      end else if (sel < 85 && seq_len > 0) begin
        rq = make_good_query();
      end else begin
        rq = make_bad_query();
      end
      issue(rq, 1'b0, no_pin);
    end

    // Closing stretch: a whole-length scan and mixed requests, no idling
    calm = 1'b1;
    issue(make_query(1, seq_len), 1'b0, no_pin);
    issue(make_query(seq_len, seq_len), 1'b0, no_pin);
    issue(make_insert(1024, VAL_MIN), 1'b0, no_pin);
    issue(make_insert(0, VAL_MAX), 1'b0, no_pin);
    for (n = 0; n < TAIL_COUNT; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)      rq = make_insert($urandom_range(0, 1024), pick_value());
      else if (sel < 85) rq = make_good_query();
      else               rq = make_bad_query();
      issue(rq, 1'b0, no_pin);
    end

    // Drain
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
